/* rtl/bid_pkg.sv */
// Shared types and constants of the 3x3 binary dilation unit.
`timescale 1ns / 1ps

package bid_pkg;

	// Fixed field widths of the stream and configuration ports.
	localparam int ROW_W       = 12;
	localparam int COL_W       = 10;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Defaults of the top level parameters and reset values of the registers.
	localparam int DEFAULT_MAX_WIDTH  = 1024;
	localparam int DEFAULT_MAX_HEIGHT = 4096;
	localparam int RESET_WIDTH        = 640;
	localparam int RESET_HEIGHT       = 480;

	// Depth of the job queue between the front and the back part.
	localparam int QUEUE_DEPTH = 4;

	// One classified pixel: an optional interior result for the centre one row and
	// one column back, and an optional border result for the pixel itself.
	typedef struct packed {
		logic             ctr_vld;
		logic             ctr_val;
		logic             brd_vld;
		logic             pix;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} job_t;

endpackage

/* rtl/binary_image_dilation_3x3_unit.sv */
// Top level of the streaming 3x3 binary dilation unit with border pass-through.
//
//  Channel   Direction  Handshake           Content
//  s_*       in         s_tvalid/s_tready   one binary pixel per transfer, raster order
//  m_*       out        m_tvalid/m_tready   one result per transfer, tlast on the last
//  cfg_*     in         cfg_we              image_width (index 0), image_height (index 1)
//
// One pixel is accepted per cycle while the job queue has room. A pixel that causes
// two results holds the output for two transfers, and the four-entry job queue absorbs
// that while the front keeps accepting until the queue is full. The line store is read
// at acceptance and written when stage one moves on, with a bypass for back-to-back
// pixels in the same column. Reset needs no clearing pass: the line store is left
// uncleared, as no result depends on entries from an earlier frame.
`timescale 1ns / 1ps

module binary_image_dilation_3x3_unit #(
	parameter int MAX_WIDTH  = bid_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = bid_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bid_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] pixel_in, [7:1] zero
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bid_pkg::OUT_TDATA_W-1:0] m_tdata,   // [11:0] out_row, [21:12] out_col,
	                                                    // [22] out_value, [23] zero
	output logic                            m_tlast,   // last_of_run
	input  logic                            cfg_we,
	input  logic [bid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bid_pkg::CFG_W-1:0]       cfg_data
);

	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          head_vld;
	bid_pkg::job_t push_job;
	bid_pkg::job_t head_job;

	bid_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	bid_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.head_vld (head_vld),
		.head_job (head_job)
	);

	bid_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_vld (head_vld),
		.head_job (head_job),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* rtl/bid_front.sv */
// Front part: pixel acceptance, raster counters, line store, window and classification.
`timescale 1ns / 1ps

module bid_front #(
	parameter int MAX_WIDTH  = bid_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = bid_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bid_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                             cfg_we,
	input  logic [bid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bid_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             q_full,
	output logic                             q_push,
	output bid_pkg::job_t                    q_job
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	// Last index of a dimension after saturation into the range one to the maximum.
	function automatic int unsigned dim_last(int unsigned v, int unsigned maxv);
		int unsigned res;
		if (v == 0) begin
			res = 0;
		end else if (v > maxv) begin
			res = maxv - 1;
		end else begin
			res = v - 1;
		end
		return res;
	endfunction

	logic [CW-1:0] w_last_q;
	logic [RW-1:0] h_last_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          accept;
	logic          cfg_hit;

	logic          s1_vld_q;
	logic          s1_adv;
	logic          pix_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic [1:0]    rd_s1;
	logic          fwd_s1;
	logic [1:0]    fwd_dat_s1;
	logic [1:0]    up_cur;
	logic [1:0]    or_q;
	logic          col_bit;
	logic          win_bit;
	logic          ctr_vld;
	logic          brd_vld;

	// Line store: bit 0 holds the previous row, bit 1 the row before that.
	logic [1:0]    line_mem [MAX_WIDTH];

	assign cfg_hit  = cfg_we && (cfg_index == bid_pkg::REG_IMAGE_WIDTH ||
	                             cfg_index == bid_pkg::REG_IMAGE_HEIGHT);
	assign s1_adv   = s1_vld_q && !q_full;
	assign s_tready = !s1_vld_q || s1_adv;
	assign accept   = s_tvalid && s_tready;

	// Frame dimensions, held as last column and last row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= CW'(dim_last(bid_pkg::RESET_WIDTH, MAX_WIDTH));
			h_last_q <= RW'(dim_last(bid_pkg::RESET_HEIGHT, MAX_HEIGHT));
		end else if (cfg_we) begin
			case (cfg_index)
				bid_pkg::REG_IMAGE_WIDTH: begin
					w_last_q <= CW'(dim_last(int'(cfg_data[bid_pkg::WIDTH_REG_W-1:0]),
					                         MAX_WIDTH));
				end
				bid_pkg::REG_IMAGE_HEIGHT: begin
					h_last_q <= RW'(dim_last(int'(cfg_data[bid_pkg::HEIGHT_REG_W-1:0]),
					                         MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	// Raster position of the next pixel; a register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == w_last_q) begin
				col_q <= '0;
				row_q <= (row_q == h_last_q) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage one control: holds the accepted pixel until the queue takes its job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	// Stage one payload, with a bypass when the read hits the column being written.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= s_tdata[0];
			col_s1     <= col_q;
			row_s1     <= row_q;
			fwd_s1     <= s1_adv && (col_s1 == col_q);
			fwd_dat_s1 <= {up_cur[0], pix_s1};
		end
	end

	// Line store read at acceptance and read-modify-write when stage one moves on.
	// Entries left from before reset are only ever read for rows that produce no
	// interior result, so the store needs no clearing.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			line_mem[col_s1] <= {up_cur[0], pix_s1};
		end
		if (accept) begin
			rd_s1 <= line_mem[col_q];
		end
	end

	assign up_cur = fwd_s1 ? fwd_dat_s1 : rd_s1;

	// The window is kept as the OR of each of the two previous columns.
	assign col_bit = up_cur[1] | up_cur[0] | pix_s1;
	assign win_bit = col_bit | or_q[0] | or_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			or_q <= '0;
		end else if (cfg_hit) begin
			or_q <= '0;
		end else if (s1_adv) begin
			or_q <= {or_q[0], col_bit};
		end
	end

	// Classification of the pixel in stage one.
	assign ctr_vld = (row_s1 >= RW'(2)) && (col_s1 >= CW'(2));
	assign brd_vld = (row_s1 == '0) || (col_s1 == '0) ||
	                 (row_s1 == h_last_q) || (col_s1 == w_last_q);

	always_comb begin
		q_job.ctr_vld = ctr_vld;
		q_job.ctr_val = win_bit;
		q_job.brd_vld = brd_vld;
		q_job.pix     = pix_s1;
		q_job.row     = bid_pkg::ROW_W'(row_s1);
		q_job.col     = bid_pkg::COL_W'(col_s1);
	end

	assign q_push = s1_adv && (ctr_vld || brd_vld);

	// An accepted pixel always occupies stage one in the following cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_vld_q)
		else $error("accepted pixel did not reach stage one");

	// Input back-pressure arises only from a full job queue.
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_vld_q && q_full))
		else $error("input stalled without a full queue");

endmodule

/* rtl/bid_queue.sv */
// Job queue between the front and the back part.
`timescale 1ns / 1ps

module bid_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bid_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_vld,
	output bid_pkg::job_t head_job
);

	localparam int DEPTH = bid_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	bid_pkg::job_t entry_q [DEPTH];

	assign full     = (count_q == NW'(DEPTH));
	assign head_vld = (count_q != '0);
	assign head_job = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_vld)
		else $error("job popped from an empty queue");

endmodule

/* rtl/bid_back.sv */
// Back part: turns each queued job into one or two result transfers.
`timescale 1ns / 1ps

module bid_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_vld,
	input  bid_pkg::job_t                   head_job,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bid_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast
);

	logic                     phase_q;
	logic                     emit_ctr;
	logic                     xfer;
	logic [bid_pkg::ROW_W-1:0] row_o;
	logic [bid_pkg::COL_W-1:0] col_o;
	logic                     val_o;

	// The interior result goes first; the border result of the same pixel follows.
	assign emit_ctr = head_job.ctr_vld && !phase_q;
	assign row_o    = emit_ctr ? head_job.row - bid_pkg::ROW_W'(1) : head_job.row;
	assign col_o    = emit_ctr ? head_job.col - bid_pkg::COL_W'(1) : head_job.col;
	assign val_o    = emit_ctr ? head_job.ctr_val : head_job.pix;

	assign m_tvalid = head_vld;
	assign m_tlast  = !emit_ctr || !head_job.brd_vld;
	assign m_tdata  = {1'b0, val_o, col_o, row_o};
	assign xfer     = m_tvalid && m_tready;
	assign pop      = xfer && m_tlast;

	// Set after the interior result of a job that still owes its border result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (xfer) begin
			phase_q <= !m_tlast;
		end
	end

	a_job_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		head_vld |-> (head_job.ctr_vld || head_job.brd_vld))
		else $error("queued job carries no result");

	a_phase_pending_border: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (head_vld && head_job.ctr_vld && head_job.brd_vld))
		else $error("second result pending without a two-result job");

endmodule

/* tb/sv/binary_image_dilation_3x3_unit_tb.sv */
// Self-checking testbench of the 3x3 binary dilation unit, with its own dilation predictor.
`timescale 1ns / 1ps

module binary_image_dilation_3x3_unit_tb;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_CYCLES  = 20;
	localparam int QUIET_TAIL    = 150;
	localparam int RANDOM_PIXELS = 40;

	// Register indexes that the unit ignores.
	localparam logic [bid_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [bid_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

	typedef enum logic [1:0] {
		OP_PIXEL,
		OP_WRITE,
		OP_HOLD
	} op_kind_t;

	typedef struct {
		op_kind_t                      kind;
		bit                            pix;
		logic [bid_pkg::CFG_IDX_W-1:0] idx;
		logic [bid_pkg::CFG_W-1:0]     data;
	} stim_op_t;

	typedef struct packed {
		logic [bid_pkg::ROW_W-1:0] row;
		logic [bid_pkg::COL_W-1:0] col;
		logic                      value;
		logic                      last;
	} dil_result_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [bid_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [bid_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            m_tlast;
	logic                            cfg_we    = 1'b0;
	logic [bid_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [bid_pkg::CFG_W-1:0]       cfg_data  = '0;

	// Stimulus still to be driven and results still to be seen.
	stim_op_t    pending_ops[$];
	dil_result_t dilation_expected[$];

	// Predictor state: two previous rows, the window, the position and the registers.
	bit                               prev_line  [bid_pkg::DEFAULT_MAX_WIDTH];
	bit                               older_line [bid_pkg::DEFAULT_MAX_WIDTH];
	logic [8:0]                       nbhd_bits  = '0;
	int unsigned                      row_pos    = 0;
	int unsigned                      col_pos    = 0;
	logic [bid_pkg::WIDTH_REG_W-1:0]  width_reg  =
		bid_pkg::WIDTH_REG_W'(bid_pkg::RESET_WIDTH);
	logic [bid_pkg::HEIGHT_REG_W-1:0] height_reg =
		bid_pkg::HEIGHT_REG_W'(bid_pkg::RESET_HEIGHT);

	int          error_count  = 0;
	int unsigned cycle_count  = 0;
	int          quiet_cycles = 0;
	int          send_gap     = 0;
	bit          gap_taken    = 1'b0;
	int          recv_stall   = 0;
	bit          stall_taken  = 1'b0;

	binary_image_dilation_3x3_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock of 10 ns.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// A register value of zero acts as one, and a value above the maximum saturates.
	function automatic int unsigned span_of(input int unsigned reg_val,
			input int unsigned limit);
		if (reg_val == 0)
			return 1;
		if (reg_val > limit)
			return limit;
		return reg_val;
	endfunction

	// Idling is allowed except in the tail of the run and in some quiet windows.
	function automatic bit idle_allowed();
		return pending_ops.size() >= QUIET_TAIL && ((cycle_count / 2000) % 4) != 3;
	endfunction

	// A write to either register restarts the frame; other indexes are ignored.
	function automatic void apply_register(input logic [bid_pkg::CFG_IDX_W-1:0] idx,
			input logic [bid_pkg::CFG_W-1:0] data);
		case (idx)
			bid_pkg::REG_IMAGE_WIDTH: begin
				width_reg = data[bid_pkg::WIDTH_REG_W-1:0];
			end
			bid_pkg::REG_IMAGE_HEIGHT: begin
				height_reg = data[bid_pkg::HEIGHT_REG_W-1:0];
			end
			default: begin
				return;
			end
		endcase
		row_pos   = 0;
		col_pos   = 0;
		nbhd_bits = '0;
	endfunction

	// Works out the results of one accepted pixel: the interior centre one row and one
	// column back first, then the pixel itself if it lies on the border.
	function automatic void predict_dilation(input bit pix);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		bit          up1;
		bit          up2;
		dil_result_t fresh[2];
		int          n;
		w   = span_of(width_reg, bid_pkg::DEFAULT_MAX_WIDTH);
		h   = span_of(height_reg, bid_pkg::DEFAULT_MAX_HEIGHT);
		r   = row_pos;
		c   = col_pos;
		n   = 0;
		up1 = prev_line[c];
		up2 = older_line[c];
		older_line[c] = up1;
		prev_line[c]  = pix;
		nbhd_bits = {nbhd_bits[5:0], up2, up1, pix};
		if (r >= 2 && c >= 2) begin
			fresh[n] = '{row: bid_pkg::ROW_W'(r - 1), col: bid_pkg::COL_W'(c - 1),
				value: |nbhd_bits, last: 1'b0};
			n++;
		end
		if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w) begin
			fresh[n] = '{row: bid_pkg::ROW_W'(r), col: bid_pkg::COL_W'(c),
				value: pix, last: 1'b0};
			n++;
		end
		if (n > 0)
			fresh[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			dilation_expected.push_back(fresh[i]);
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic push_pixel(input bit pix);
		pending_ops.push_back('{kind: OP_PIXEL, pix: pix, idx: '0, data: '0});
	endtask

	task automatic push_write(input logic [bid_pkg::CFG_IDX_W-1:0] idx,
			input logic [bid_pkg::CFG_W-1:0] data);
		pending_ops.push_back('{kind: OP_WRITE, pix: 1'b0, idx: idx, data: data});
	endtask

	task automatic push_hold();
		pending_ops.push_back('{kind: OP_HOLD, pix: 1'b0, idx: '0, data: '0});
	endtask

	// Queues a run of pixels with a random density of set bits, optionally broken by an
	// ignored register write or by a hold until all results have come.
	task automatic queue_pixels(input int n, input bit poke_unused, input bit hold_mid);
		int thr;
		int split;
		case ($urandom_range(0, 2))
			0: thr = 1;
			1: thr = 8;
			default: thr = 15;
		endcase
		split = $urandom_range(0, n);
		for (int i = 0; i < n; i++) begin
			if (i == split && poke_unused)
				push_write($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
					bid_pkg::CFG_W'($urandom_range(0, 8191)));
			if (i == split && hold_mid)
				push_hold();
			push_pixel($urandom_range(0, 15) < thr);
		end
	endtask

	// Pixel driver and configuration writer.
	always @(posedge clk) begin : pixel_driver
		logic                           nxt_valid;
		logic [bid_pkg::IN_TDATA_W-1:0] nxt_data;
		logic                           nxt_we;
		logic [bid_pkg::CFG_IDX_W-1:0]  nxt_idx;
		logic [bid_pkg::CFG_W-1:0]      nxt_cfg;
		stim_op_t                       op;
		if (arst_n) begin
			nxt_valid = s_tvalid;
			nxt_data  = s_tdata;
			nxt_we    = 1'b0;
			nxt_idx   = cfg_index;
			nxt_cfg   = cfg_data;
			if (dilation_expected.size() == 0 && !s_tvalid)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (s_tvalid && s_tready) begin
				predict_dilation(s_tdata[0]);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_ops.size() > 0) begin
					op = pending_ops[0];
					case (op.kind)
						OP_PIXEL: begin
							if (idle_allowed() && !gap_taken && $urandom_range(0, 9) == 0) begin
								send_gap  = $urandom_range(1, 19) - 1;
								gap_taken = 1'b1;
							end else begin
								gap_taken = 1'b0;
								nxt_valid = 1'b1;
								nxt_data  = {{(bid_pkg::IN_TDATA_W-1){1'b0}}, op.pix};
								void'(pending_ops.pop_front());
							end
						end
						OP_WRITE: begin
							if (quiet_cycles >= SETTLE_CYCLES) begin
								nxt_we  = 1'b1;
								nxt_idx = op.idx;
								nxt_cfg = op.data;
								apply_register(op.idx, op.data);
								void'(pending_ops.pop_front());
							end
						end
						default: begin
							if (quiet_cycles >= SETTLE_CYCLES)
								void'(pending_ops.pop_front());
						end
					endcase
				end
			end
			s_tvalid  <= nxt_valid;
			s_tdata   <= nxt_data;
			cfg_we    <= nxt_we;
			cfg_index <= nxt_idx;
			cfg_data  <= nxt_cfg;
		end
	end

	// Result monitor and receiver stalls.
	always @(posedge clk) begin : result_monitor
		dil_result_t got;
		dil_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.row   = m_tdata[bid_pkg::ROW_W-1:0];
				got.col   = m_tdata[bid_pkg::ROW_W+bid_pkg::COL_W-1:bid_pkg::ROW_W];
				got.value = m_tdata[bid_pkg::ROW_W+bid_pkg::COL_W];
				got.last  = m_tlast;
				if (dilation_expected.size() == 0) begin
					report_mismatch($sformatf("result row %0d col %0d with none expected",
						got.row, got.col));
				end else begin
					want = dilation_expected.pop_front();
					if (got.row !== want.row)
						report_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
					if (got.col !== want.col)
						report_mismatch($sformatf("col %0d, expected %0d at row %0d",
							got.col, want.col, want.row));
					if (got.value !== want.value)
						report_mismatch($sformatf("value %b, expected %b at row %0d col %0d",
							got.value, want.value, want.row, want.col));
					if (got.last !== want.last)
						report_mismatch($sformatf("tlast %b, expected %b at row %0d col %0d",
							got.last, want.last, want.row, want.col));
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else if (idle_allowed() && !stall_taken && $urandom_range(0, 9) == 0) begin
				recv_stall  = $urandom_range(1, 19) - 1;
				stall_taken = 1'b1;
				m_tready    <= 1'b0;
			end else begin
				stall_taken = 1'b0;
				m_tready    <= 1'b1;
			end
		end
	end

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		int                        random_pixels;
		int                        which;
		int                        n;
		int unsigned               cur_w;
		int unsigned               cur_h;
		logic [bid_pkg::CFG_W-1:0] wv;
		logic [bid_pkg::CFG_W-1:0] hv;
		logic [bid_pkg::CFG_W-1:0] width_picks[8];
		logic [bid_pkg::CFG_W-1:0] height_picks[8];
		width_picks  = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd1024, 13'd2047, 13'd1023, 13'h1805};
		height_picks = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd4096, 13'd8191, 13'd4095, 13'h1000};
		for (int i = 0; i < bid_pkg::DEFAULT_MAX_WIDTH; i++) begin
			prev_line[i]  = 1'b0;
			older_line[i] = 1'b0;
		end

		// Directed: start of the first row of the reset geometry.
		push_pixel(1'b1);
		push_pixel(1'b0);
		push_pixel(1'b1);
		// Smallest frame with an interior: a corner pixel spreads to the centre.
		push_write(bid_pkg::REG_IMAGE_WIDTH, 13'd3);
		push_write(bid_pkg::REG_IMAGE_HEIGHT, 13'd3);
		push_pixel(1'b1);
		repeat (8) push_pixel(1'b0);
		// Only the last pixel set, with an ignored write in mid frame.
		repeat (4) push_pixel(1'b0);
		push_write(REG_UNUSED_2, 13'h1fff);
		repeat (4) push_pixel(1'b0);
		push_pixel(1'b1);
		// Zero registers act as a single-pixel frame.
		push_write(bid_pkg::REG_IMAGE_WIDTH, 13'd0);
		push_write(bid_pkg::REG_IMAGE_HEIGHT, 13'd0);
		push_pixel(1'b1);
		push_pixel(1'b0);

		// Widest frame, saturated: the whole first row and the start of the second.
		push_write(bid_pkg::REG_IMAGE_WIDTH, 13'd2047);
		push_write(bid_pkg::REG_IMAGE_HEIGHT, 13'd3);
		queue_pixels(bid_pkg::DEFAULT_MAX_WIDTH + 30, 1'b0, 1'b1);
		// Tallest frame, saturated, one pixel wide.
		push_write(bid_pkg::REG_IMAGE_WIDTH, 13'd1);
		push_write(bid_pkg::REG_IMAGE_HEIGHT, 13'd8191);
		queue_pixels(50, 1'b0, 1'b0);
		cur_w = 1;
		cur_h = bid_pkg::DEFAULT_MAX_HEIGHT;

		// Random frames, mostly small, now and then at the extremes.
		random_pixels = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			if ($urandom_range(0, 7) == 0) begin
				wv = width_picks[$urandom_range(0, 7)];
				hv = height_picks[$urandom_range(0, 7)];
			end else begin
				wv = bid_pkg::CFG_W'($urandom_range(1, 9));
				hv = bid_pkg::CFG_W'($urandom_range(1, 9));
			end
			which = $urandom_range(0, 3);
			if (which != 1) begin
				push_write(bid_pkg::REG_IMAGE_WIDTH, wv);
				cur_w = span_of(wv[bid_pkg::WIDTH_REG_W-1:0], bid_pkg::DEFAULT_MAX_WIDTH);
			end
			if (which != 0) begin
				push_write(bid_pkg::REG_IMAGE_HEIGHT, hv);
				cur_h = span_of(hv[bid_pkg::HEIGHT_REG_W-1:0], bid_pkg::DEFAULT_MAX_HEIGHT);
			end
			if (cur_w > 64)
				n = $urandom_range(20, 60);
			else if (cur_w * cur_h <= 100)
				n = $urandom_range(1, 3) * cur_w * cur_h + $urandom_range(0, cur_w);
			else
				n = cur_w * $urandom_range(3, 6) + $urandom_range(0, cur_w);
			queue_pixels(n, $urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0);
			random_pixels += n;
		end

		// Reset, then let the stimulus run out and the results drain.
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pending_ops.size() != 0 || s_tvalid)
			@(posedge clk);
		while (dilation_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
rtl/bid_pkg.sv
rtl/bid_front.sv
rtl/bid_queue.sv
rtl/bid_back.sv
rtl/binary_image_dilation_3x3_unit.sv
tb/sv/binary_image_dilation_3x3_unit_tb.sv
